FILE: sv/bhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BMP header parser.
package bhp_pkg;

  localparam int unsigned PAL_ENTRIES_DEF = 256;
  localparam int unsigned POS_W           = 6;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(53);

  localparam logic [POS_W-1:0] SIG_BASE = POS_W'(0);
  localparam logic [POS_W-1:0] SIG_END  = POS_W'(1);
  localparam logic [POS_W-1:0] OFF_BASE = POS_W'(10);
  localparam logic [POS_W-1:0] OFF_END  = POS_W'(13);
  localparam logic [POS_W-1:0] WID_BASE = POS_W'(18);
  localparam logic [POS_W-1:0] WID_END  = POS_W'(21);
  localparam logic [POS_W-1:0] HGT_BASE = POS_W'(22);
  localparam logic [POS_W-1:0] HGT_END  = POS_W'(25);
  localparam logic [POS_W-1:0] PLN_BASE = POS_W'(26);
  localparam logic [POS_W-1:0] PLN_END  = POS_W'(27);
  localparam logic [POS_W-1:0] DEP_BASE = POS_W'(28);
  localparam logic [POS_W-1:0] DEP_END  = POS_W'(29);
  localparam logic [POS_W-1:0] CMP_BASE = POS_W'(30);
  localparam logic [POS_W-1:0] CMP_END  = POS_W'(33);
  localparam logic [POS_W-1:0] COL_BASE = POS_W'(46);
  localparam logic [POS_W-1:0] COL_END  = POS_W'(49);

  localparam logic [15:0] DEPTH_1BPP  = 16'd1;
  localparam logic [15:0] DEPTH_4BPP  = 16'd4;
  localparam logic [15:0] DEPTH_8BPP  = 16'd8;
  localparam logic [15:0] DEPTH_24BPP = 16'd24;
  localparam logic [15:0] DEPTH_WORD  = 16'd32;
  localparam logic [15:0] ONE_PLANE   = 16'd1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PALETTE = 3'd1,
    PH_PAD     = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIGNATURE   = 3'd1,
    ERR_PLANES      = 3'd2,
    ERR_COMPRESSED  = 3'd3,
    ERR_DEPTH       = 3'd4,
    ERR_PAL_CORRUPT = 3'd5,
    ERR_PAL_BIG     = 3'd6
  } err_t;

  typedef struct packed {
    logic               header_done;
    logic [2:0]         error_code;
    logic signed [31:0] image_width;
    logic signed [31:0] image_height;
    logic [15:0]        bits_per_pixel;
    logic [31:0]        pixel_offset;
    logic               entry_valid;
    logic [7:0]         entry_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
  } res_t;

  function automatic logic [1:0] lane_of(input logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] base);
    lane_of = 2'(pos - base);
  endfunction

endpackage

FILE: sv/bhp_core.sv
`timescale 1ns / 1ps
// Parser state, field capture, header checks and palette entry assembly.
module bhp_core #(
  parameter int unsigned PALETTE_ENTRIES = bhp_pkg::PAL_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          file_start,
  output bhp_pkg::res_t res
);

  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);

  bhp_pkg::phase_t    phase_r, phase_c, phase_nxt;
  bhp_pkg::err_t      err_r, err_c, err_nxt;
  logic [31:0]        count_r, count_c, count_nxt;
  logic [15:0]        sig_r, sig_c, sig_nxt;
  logic [31:0]        off_r, off_c, off_nxt;
  logic [31:0]        wid_r, wid_c, wid_nxt;
  logic [31:0]        hgt_r, hgt_c, hgt_nxt;
  logic [15:0]        pln_r, pln_c, pln_nxt;
  logic [15:0]        dep_r, dep_c, dep_nxt;
  logic [31:0]        cmp_r, cmp_c, cmp_nxt;
  logic [31:0]        col_r, col_c, col_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_c, cnt_nxt;
  logic [CNT_W-1:0]   lim_r, lim_c, lim_nxt;
  logic [1:0]         epos_r, epos_c, epos_nxt;
  logic [7:0]         blue_r, blue_nxt;
  logic [7:0]         green_r, green_nxt;
  logic [7:0]         red_r, red_nxt;
  logic [31:0]        col_eff;
  logic [bhp_pkg::POS_W-1:0] pos;

  function automatic bhp_pkg::phase_t off_check(input logic [31:0] cnt,
                                                input logic [31:0] off);
    if (cnt > off) off_check = bhp_pkg::PH_ERROR;
    else if (cnt == off) off_check = bhp_pkg::PH_DONE;
    else off_check = bhp_pkg::PH_PAD;
  endfunction

  always_comb begin
    if (file_start) begin
      phase_c = bhp_pkg::PH_HEADER;
      err_c   = bhp_pkg::ERR_NONE;
      count_c = '0;
      sig_c   = '0;
      off_c   = '0;
      wid_c   = '0;
      hgt_c   = '0;
      pln_c   = '0;
      dep_c   = '0;
      cmp_c   = '0;
      col_c   = '0;
      cnt_c   = '0;
      lim_c   = '0;
      epos_c  = '0;
    end else begin
      phase_c = phase_r;
      err_c   = err_r;
      count_c = count_r;
      sig_c   = sig_r;
      off_c   = off_r;
      wid_c   = wid_r;
      hgt_c   = hgt_r;
      pln_c   = pln_r;
      dep_c   = dep_r;
      cmp_c   = cmp_r;
      col_c   = col_r;
      cnt_c   = cnt_r;
      lim_c   = lim_r;
      epos_c  = epos_r;
    end
  end

  always_comb begin
    phase_nxt = phase_c;
    err_nxt   = err_c;
    count_nxt = (count_c == '1) ? count_c : count_c + 32'd1;
    sig_nxt   = sig_c;
    off_nxt   = off_c;
    wid_nxt   = wid_c;
    hgt_nxt   = hgt_c;
    pln_nxt   = pln_c;
    dep_nxt   = dep_c;
    cmp_nxt   = cmp_c;
    col_nxt   = col_c;
    cnt_nxt   = cnt_c;
    lim_nxt   = lim_c;
    epos_nxt  = epos_c;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    pos       = count_c[bhp_pkg::POS_W-1:0];
    col_eff   = col_c;
    res       = '0;

    unique case (phase_c)
      bhp_pkg::PH_HEADER: begin
        case (pos) inside
          [bhp_pkg::SIG_BASE:bhp_pkg::SIG_END]:
            sig_nxt[{pos[0], 3'b000} +: 8] = data_byte;
          [bhp_pkg::OFF_BASE:bhp_pkg::OFF_END]:
            off_nxt[{bhp_pkg::lane_of(pos, bhp_pkg::OFF_BASE), 3'b000} +: 8] = data_byte;
          [bhp_pkg::WID_BASE:bhp_pkg::WID_END]:
            wid_nxt[{bhp_pkg::lane_of(pos, bhp_pkg::WID_BASE), 3'b000} +: 8] = data_byte;
          [bhp_pkg::HGT_BASE:bhp_pkg::HGT_END]:
            hgt_nxt[{bhp_pkg::lane_of(pos, bhp_pkg::HGT_BASE), 3'b000} +: 8] = data_byte;
          [bhp_pkg::PLN_BASE:bhp_pkg::PLN_END]:
            pln_nxt[{pos[0], 3'b000} +: 8] = data_byte;
          [bhp_pkg::DEP_BASE:bhp_pkg::DEP_END]:
            dep_nxt[{pos[0], 3'b000} +: 8] = data_byte;
          [bhp_pkg::CMP_BASE:bhp_pkg::CMP_END]:
            cmp_nxt[{bhp_pkg::lane_of(pos, bhp_pkg::CMP_BASE), 3'b000} +: 8] = data_byte;
          [bhp_pkg::COL_BASE:bhp_pkg::COL_END]:
            col_nxt[{bhp_pkg::lane_of(pos, bhp_pkg::COL_BASE), 3'b000} +: 8] = data_byte;
          default: ;
        endcase
        if (col_nxt == '0) begin
          col_eff = (dep_nxt < bhp_pkg::DEPTH_WORD) ? (32'd1 << dep_nxt[4:0]) : 32'd0;
        end else begin
          col_eff = col_nxt;
        end
        if (pos == bhp_pkg::HDR_LAST_POS) begin
          if (sig_nxt != bhp_pkg::BMP_SIGNATURE) begin
            err_nxt   = bhp_pkg::ERR_SIGNATURE;
            phase_nxt = bhp_pkg::PH_ERROR;
          end else if (pln_nxt != bhp_pkg::ONE_PLANE) begin
            err_nxt   = bhp_pkg::ERR_PLANES;
            phase_nxt = bhp_pkg::PH_ERROR;
          end else if (cmp_nxt != '0) begin
            err_nxt   = bhp_pkg::ERR_COMPRESSED;
            phase_nxt = bhp_pkg::PH_ERROR;
          end else if (dep_nxt == bhp_pkg::DEPTH_1BPP || dep_nxt == bhp_pkg::DEPTH_4BPP ||
                       dep_nxt == bhp_pkg::DEPTH_24BPP) begin
            err_nxt   = bhp_pkg::ERR_DEPTH;
            phase_nxt = bhp_pkg::PH_ERROR;
          end else if (dep_nxt == bhp_pkg::DEPTH_8BPP) begin
            if (col_eff > 32'(PALETTE_ENTRIES)) begin
              err_nxt   = bhp_pkg::ERR_PAL_BIG;
              phase_nxt = bhp_pkg::PH_ERROR;
            end else begin
              phase_nxt = bhp_pkg::PH_PALETTE;
              cnt_nxt   = '0;
              epos_nxt  = '0;
              lim_nxt   = col_eff[CNT_W-1:0];
            end
          end else begin
            phase_nxt = off_check(count_nxt, off_nxt);
            if (phase_nxt == bhp_pkg::PH_ERROR) err_nxt = bhp_pkg::ERR_PAL_CORRUPT;
            res.header_done = (phase_nxt == bhp_pkg::PH_DONE);
          end
        end
      end
      bhp_pkg::PH_PALETTE: begin
        epos_nxt = epos_c + 2'd1;
        case (epos_c)
          2'd0: blue_nxt  = data_byte;
          2'd1: green_nxt = data_byte;
          2'd2: red_nxt   = data_byte;
          default: begin
            res.entry_valid = 1'b1;
            res.entry_index = 8'(cnt_c);
            res.entry_red   = red_r;
            res.entry_green = green_r;
            res.entry_blue  = blue_r;
            cnt_nxt = cnt_c + CNT_W'(1);
            if (cnt_nxt >= lim_c) begin
              phase_nxt = off_check(count_nxt, off_c);
              if (phase_nxt == bhp_pkg::PH_ERROR) err_nxt = bhp_pkg::ERR_PAL_CORRUPT;
              res.header_done = (phase_nxt == bhp_pkg::PH_DONE);
            end
          end
        endcase
      end
      bhp_pkg::PH_PAD: begin
        if (count_nxt >= off_c) begin
          phase_nxt       = bhp_pkg::PH_DONE;
          res.header_done = 1'b1;
        end
      end
      default: ;
    endcase

    res.error_code     = err_nxt;
    res.image_width    = wid_nxt;
    res.image_height   = hgt_nxt;
    res.bits_per_pixel = dep_nxt;
    res.pixel_offset   = off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bhp_pkg::PH_HEADER;
      err_r   <= bhp_pkg::ERR_NONE;
      count_r <= '0;
      sig_r   <= '0;
      off_r   <= '0;
      wid_r   <= '0;
      hgt_r   <= '0;
      pln_r   <= '0;
      dep_r   <= '0;
      cmp_r   <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
      lim_r   <= '0;
      epos_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
      sig_r   <= sig_nxt;
      off_r   <= off_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      pln_r   <= pln_nxt;
      dep_r   <= dep_nxt;
      cmp_r   <= cmp_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      lim_r   <= lim_nxt;
      epos_r  <= epos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bhp_pkg::PH_ERROR) == (err_r != bhp_pkg::ERR_NONE))
    else $error("error code and error phase disagree");

  a_epos_palette: assert property (@(posedge clk) disable iff (!rst_n)
    epos_r != 2'd0 |-> phase_r == bhp_pkg::PH_PALETTE)
    else $error("entry byte position left nonzero outside palette");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bhp_pkg::PH_PALETTE |-> cnt_r < lim_r)
    else $error("palette counter reached limit inside palette phase");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.header_done |=> phase_r == bhp_pkg::PH_DONE &&
      err_r == bhp_pkg::ERR_NONE)
    else $error("header done without entering done phase");

endmodule

FILE: sv/bhp_obuf.sv
`timescale 1ns / 1ps
// Result register with one skid entry for the output channel.
module bhp_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bhp_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output bhp_pkg::res_t out_data
);

  logic          main_v_r, main_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  bhp_pkg::res_t main_d_r, skid_d_r;
  logic          pop;
  logic          load_main, load_skid, move_skid;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    load_main  = 1'b0;
    load_skid  = 1'b0;
    move_skid  = 1'b0;
    if (skid_v_r) begin
      if (pop) begin
        move_skid  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        load_main  = 1'b1;
        main_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) main_d_r <= skid_d_r;
    else if (load_main) main_d_r <= push_data;
    if (load_skid) skid_d_r <= push_data;
  end

  a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held while result register empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> main_v_r && !skid_v_r)
    else $error("skid entry not moved into result register");

endmodule

FILE: sv/bmp_header_parser.sv
`timescale 1ns / 1ps
// Top level of the byte-serial BMP header parser.
// A result is registered in the output stage's result register, or in its skid entry when that is busy.
// Throughput: one byte per cycle while in_stall is low; the state update is a single registered pass.
// A two-entry output stage (result register plus skid entry) absorbs out_stall.
// Reset (rst_n low, synchronous) clears parser state, but not the colour hold registers, to the header phase.
// in_file_start clears the parse state before its byte is taken.
module bmp_header_parser #(
  parameter int unsigned PALETTE_ENTRIES = bhp_pkg::PAL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_file_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_header_done,
  output logic [2:0]         out_error_code,
  output logic signed [31:0] out_image_width,
  output logic signed [31:0] out_image_height,
  output logic [15:0]        out_bits_per_pixel,
  output logic [31:0]        out_pixel_offset,
  output logic               out_entry_valid,
  output logic [7:0]         out_entry_index,
  output logic [7:0]         out_entry_red,
  output logic [7:0]         out_entry_green,
  output logic [7:0]         out_entry_blue
);

  logic          take;
  logic          full;
  bhp_pkg::res_t res;
  bhp_pkg::res_t out_res;

  assign in_stall = full;
  assign take     = in_valid && !full;

  bhp_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .file_start(in_file_start),
    .res       (res)
  );

  bhp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_data(res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_header_done    = out_res.header_done;
  assign out_error_code     = out_res.error_code;
  assign out_image_width    = out_res.image_width;
  assign out_image_height   = out_res.image_height;
  assign out_bits_per_pixel = out_res.bits_per_pixel;
  assign out_pixel_offset   = out_res.pixel_offset;
  assign out_entry_valid    = out_res.entry_valid;
  assign out_entry_index    = out_res.entry_index;
  assign out_entry_red      = out_res.entry_red;
  assign out_entry_green    = out_res.entry_green;
  assign out_entry_blue     = out_res.entry_blue;

endmodule

FILE: dv/bmp_header_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BMP header parser: directed files, then random byte streams.
module bmp_header_parser_test;

  localparam int unsigned PAL_MAX        = bhp_pkg::PAL_ENTRIES_DEF;
  localparam int          HDR_BYTES      = 54;
  localparam int          FILE_CAP       = HDR_BYTES + 4 * 256 + 64;
  localparam int          PLAN_ROWS      = 8;
  localparam int          ITEM_TOTAL     = 560;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [15:0] SIG_OK         = bhp_pkg::BMP_SIGNATURE;
  localparam logic [15:0] PLN_OK         = bhp_pkg::ONE_PLANE;
  localparam logic [15:0] D8             = bhp_pkg::DEPTH_8BPP;

  typedef struct {
    logic            fs;
    logic [15:0]     sig;
    logic [15:0]     planes;
    logic [15:0]     depth;
    logic [31:0]     compress;
    logic [31:0]     colors;
    logic [31:0]     offset;
    logic [31:0]     width;
    logic [31:0]     height;
    int              cut;
    int              tail;
    logic            chk;
    bhp_pkg::err_t   err;
  } bmp_file_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte  = 8'h00;
  logic               in_file_start = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               out_header_done;
  logic [2:0]         out_error_code;
  logic signed [31:0] out_image_width;
  logic signed [31:0] out_image_height;
  logic [15:0]        out_bits_per_pixel;
  logic [31:0]        out_pixel_offset;
  logic               out_entry_valid;
  logic [7:0]         out_entry_index;
  logic [7:0]         out_entry_red;
  logic [7:0]         out_entry_green;
  logic [7:0]         out_entry_blue;

  logic [31:0]     bytes_seen;
  bhp_pkg::phase_t stage;
  logic [15:0]     sig_word;
  logic [31:0]     offset_word;
  logic [31:0]     width_word;
  logic [31:0]     height_word;
  logic [15:0]     planes_word;
  logic [15:0]     depth_word;
  logic [31:0]     compress_word;
  logic [31:0]     colors_word;
  logic [8:0]      entry_num;
  logic [1:0]      entry_lane;
  logic [7:0]      blue_hold;
  logic [7:0]      green_hold;
  logic [7:0]      red_hold;
  bhp_pkg::err_t   fault;

  bhp_pkg::res_t parse_results [$];
  bhp_pkg::res_t seen_res;
  bhp_pkg::res_t want_res;
  bmp_file_t     plan [PLAN_ROWS];
  int            mismatches  = 0;
  int            idle_cycles = 0;
  int            burst_left  = 0;
  int            stall_mode  = 0;
  int            stall_left  = 0;
  int            stall_tick  = 0;
  int            sent        = 0;

  bmp_header_parser #(
    .PALETTE_ENTRIES(PAL_MAX)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_file_start      (in_file_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_header_done    (out_header_done),
    .out_error_code     (out_error_code),
    .out_image_width    (out_image_width),
    .out_image_height   (out_image_height),
    .out_bits_per_pixel (out_bits_per_pixel),
    .out_pixel_offset   (out_pixel_offset),
    .out_entry_valid    (out_entry_valid),
    .out_entry_index    (out_entry_index),
    .out_entry_red      (out_entry_red),
    .out_entry_green    (out_entry_green),
    .out_entry_blue     (out_entry_blue)
  );

  always #2 clk = ~clk;

  function automatic void clear_parse();
    bytes_seen    = '0;
    stage         = bhp_pkg::PH_HEADER;
    sig_word      = '0;
    offset_word   = '0;
    width_word    = '0;
    height_word   = '0;
    planes_word   = '0;
    depth_word    = '0;
    compress_word = '0;
    colors_word   = '0;
    entry_num     = '0;
    entry_lane    = '0;
    blue_hold     = '0;
    green_hold    = '0;
    red_hold      = '0;
    fault         = bhp_pkg::ERR_NONE;
  endfunction

  function automatic void bump_count();
    if (bytes_seen != 32'hFFFF_FFFF) bytes_seen = bytes_seen + 32'd1;
  endfunction

  function automatic void fail_with(input bhp_pkg::err_t code);
    fault = code;
    stage = bhp_pkg::PH_ERROR;
  endfunction

  function automatic void capture(input int p, input logic [7:0] b);
    if (p < 2) sig_word[8*p +: 8] = b;
    else if (p >= int'(bhp_pkg::OFF_BASE) && p <= int'(bhp_pkg::OFF_END))
      offset_word[8*(p-int'(bhp_pkg::OFF_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::WID_BASE) && p <= int'(bhp_pkg::WID_END))
      width_word[8*(p-int'(bhp_pkg::WID_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::HGT_BASE) && p <= int'(bhp_pkg::HGT_END))
      height_word[8*(p-int'(bhp_pkg::HGT_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::PLN_BASE) && p <= int'(bhp_pkg::PLN_END))
      planes_word[8*(p-int'(bhp_pkg::PLN_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::DEP_BASE) && p <= int'(bhp_pkg::DEP_END))
      depth_word[8*(p-int'(bhp_pkg::DEP_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::CMP_BASE) && p <= int'(bhp_pkg::CMP_END))
      compress_word[8*(p-int'(bhp_pkg::CMP_BASE)) +: 8] = b;
    else if (p >= int'(bhp_pkg::COL_BASE) && p <= int'(bhp_pkg::COL_END))
      colors_word[8*(p-int'(bhp_pkg::COL_BASE)) +: 8] = b;
  endfunction

  function automatic logic reach_offset();
    if (bytes_seen > offset_word) begin
      fail_with(bhp_pkg::ERR_PAL_CORRUPT);
      return 1'b0;
    end
    if (bytes_seen == offset_word) begin
      stage = bhp_pkg::PH_DONE;
      return 1'b1;
    end
    stage = bhp_pkg::PH_PAD;
    return 1'b0;
  endfunction

  function automatic logic vet_header();
    if (sig_word != bhp_pkg::BMP_SIGNATURE) begin
      fail_with(bhp_pkg::ERR_SIGNATURE);
      return 1'b0;
    end
    if (planes_word != bhp_pkg::ONE_PLANE) begin
      fail_with(bhp_pkg::ERR_PLANES);
      return 1'b0;
    end
    if (compress_word != 32'd0) begin
      fail_with(bhp_pkg::ERR_COMPRESSED);
      return 1'b0;
    end
    if (colors_word == 32'd0)
      colors_word = (depth_word < bhp_pkg::DEPTH_WORD) ? (32'd1 << depth_word) : 32'd0;
    if (depth_word == bhp_pkg::DEPTH_1BPP || depth_word == bhp_pkg::DEPTH_4BPP ||
        depth_word == bhp_pkg::DEPTH_24BPP) begin
      fail_with(bhp_pkg::ERR_DEPTH);
      return 1'b0;
    end
    if (depth_word == bhp_pkg::DEPTH_8BPP) begin
      if (colors_word > PAL_MAX) begin
        fail_with(bhp_pkg::ERR_PAL_BIG);
        return 1'b0;
      end
      stage      = bhp_pkg::PH_PALETTE;
      entry_num  = '0;
      entry_lane = '0;
      return 1'b0;
    end
    return reach_offset();
  endfunction

  function automatic bhp_pkg::res_t parse_byte(input logic [7:0] b, input logic fs);
    bhp_pkg::res_t r;
    r = '0;
    if (fs) clear_parse();
    case (stage)
      bhp_pkg::PH_HEADER: begin
        capture(int'(bytes_seen), b);
        bump_count();
        if (bytes_seen >= HDR_BYTES) r.header_done = vet_header();
      end
      bhp_pkg::PH_PALETTE: begin
        bump_count();
        case (entry_lane)
          2'd0: blue_hold  = b;
          2'd1: green_hold = b;
          2'd2: red_hold   = b;
          default: begin
            r.entry_valid = 1'b1;
            r.entry_index = entry_num[7:0];
            r.entry_red   = red_hold;
            r.entry_green = green_hold;
            r.entry_blue  = blue_hold;
            entry_num     = entry_num + 9'd1;
            if (entry_num >= colors_word) r.header_done = reach_offset();
          end
        endcase
        entry_lane = entry_lane + 2'd1;
      end
      bhp_pkg::PH_PAD: begin
        bump_count();
        if (bytes_seen >= offset_word) begin
          stage         = bhp_pkg::PH_DONE;
          r.header_done = 1'b1;
        end
      end
      default: bump_count();
    endcase
    r.error_code     = fault;
    r.image_width    = width_word;
    r.image_height   = height_word;
    r.bits_per_pixel = depth_word;
    r.pixel_offset   = offset_word;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_file_start <= fs;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    parse_results.push_back(parse_byte(b, fs));
    sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parse_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic feed_file(input bmp_file_t f);
    logic [7:0]    hdr [HDR_BYTES];
    bhp_pkg::res_t last;
    int            pos;
    int            k;
    bit            ended;
    for (pos = 0; pos < HDR_BYTES; pos++) hdr[pos] = 8'($urandom);
    for (k = 0; k < 2; k++) begin
      hdr[int'(bhp_pkg::SIG_BASE)+k] = f.sig[8*k +: 8];
      hdr[int'(bhp_pkg::PLN_BASE)+k] = f.planes[8*k +: 8];
      hdr[int'(bhp_pkg::DEP_BASE)+k] = f.depth[8*k +: 8];
    end
    for (k = 0; k < 4; k++) begin
      hdr[int'(bhp_pkg::OFF_BASE)+k] = f.offset[8*k +: 8];
      hdr[int'(bhp_pkg::WID_BASE)+k] = f.width[8*k +: 8];
      hdr[int'(bhp_pkg::HGT_BASE)+k] = f.height[8*k +: 8];
      hdr[int'(bhp_pkg::CMP_BASE)+k] = f.compress[8*k +: 8];
      hdr[int'(bhp_pkg::COL_BASE)+k] = f.colors[8*k +: 8];
    end
    pos   = 0;
    ended = 1'b0;
    while (!ended && pos < FILE_CAP && (f.cut == 0 || pos < f.cut)) begin
      send_byte((pos < HDR_BYTES) ? hdr[pos] : 8'($urandom), f.fs && (pos == 0));
      pos++;
      ended = (stage == bhp_pkg::PH_DONE) || (stage == bhp_pkg::PH_ERROR);
    end
    if (f.chk && ended) begin
      last = parse_results.pop_back();
      last.error_code  = f.err;
      last.header_done = (f.err == bhp_pkg::ERR_NONE);
      parse_results.push_back(last);
    end
    repeat (f.tail) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 20);
    repeat (n) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  function automatic bmp_file_t draw_file();
    bmp_file_t f;
    int        kind;
    int        base;
    kind       = $urandom_range(0, 99);
    f.fs       = 1'b1;
    f.sig      = bhp_pkg::BMP_SIGNATURE;
    f.planes   = bhp_pkg::ONE_PLANE;
    f.compress = 32'd0;
    f.width    = $urandom;
    f.height   = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: f.depth = bhp_pkg::DEPTH_8BPP;
      3:       f.depth = 16'd16;
      4:       f.depth = bhp_pkg::DEPTH_WORD;
      default: f.depth = 16'($urandom_range(0, 65535));
    endcase
    f.colors = (f.depth != D8 && $urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 6);
    base = HDR_BYTES;
    if (f.depth == D8) base += 4 * int'(f.colors);
    f.offset = base + $urandom_range(0, 6);
    f.cut    = 0;
    f.tail   = $urandom_range(0, 3);
    f.chk    = 1'b0;
    f.err    = bhp_pkg::ERR_NONE;
    if (kind >= 60 && kind < 70) begin
      f.offset = $urandom_range(0, base - 1);
    end else if (kind >= 70 && kind < 90) begin
      f.offset = $urandom;
      case ($urandom_range(0, 4))
        0: begin
          f.sig = 16'($urandom);
          if (f.sig == bhp_pkg::BMP_SIGNATURE) f.sig = ~f.sig;
        end
        1: begin
          f.planes = 16'($urandom);
          if (f.planes == bhp_pkg::ONE_PLANE) f.planes = 16'd0;
        end
        2: begin
          f.compress = $urandom;
          if (f.compress == 32'd0) f.compress = 32'd1;
        end
        3: begin
          case ($urandom_range(0, 2))
            0:       f.depth = bhp_pkg::DEPTH_1BPP;
            1:       f.depth = bhp_pkg::DEPTH_4BPP;
            default: f.depth = bhp_pkg::DEPTH_24BPP;
          endcase
        end
        default: begin
          f.depth  = bhp_pkg::DEPTH_8BPP;
          f.colors = ($urandom_range(0, 1) == 0) ? $urandom_range(PAL_MAX + 1, 4096)
                                                 : ($urandom | 32'h8000_0000);
        end
      endcase
    end else if (kind >= 90) begin
      f.cut = $urandom_range(1, base + 4);
    end
    return f;
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= (stall_tick % 4 == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_res.header_done    = out_header_done;
        seen_res.error_code     = out_error_code;
        seen_res.image_width    = out_image_width;
        seen_res.image_height   = out_image_height;
        seen_res.bits_per_pixel = out_bits_per_pixel;
        seen_res.pixel_offset   = out_pixel_offset;
        seen_res.entry_valid    = out_entry_valid;
        seen_res.entry_index    = out_entry_index;
        seen_res.entry_red      = out_entry_red;
        seen_res.entry_green    = out_entry_green;
        seen_res.entry_blue     = out_entry_blue;
        if (parse_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want_res = parse_results.pop_front();
          check_field("header_done", want_res.header_done, seen_res.header_done);
          check_field("error_code", want_res.error_code, seen_res.error_code);
          check_field("image_width", want_res.image_width, seen_res.image_width);
          check_field("image_height", want_res.image_height, seen_res.image_height);
          check_field("bits_per_pixel", want_res.bits_per_pixel, seen_res.bits_per_pixel);
          check_field("pixel_offset", want_res.pixel_offset, seen_res.pixel_offset);
          check_field("entry_valid", want_res.entry_valid, seen_res.entry_valid);
          check_field("entry_index", want_res.entry_index, seen_res.entry_index);
          check_field("entry_red", want_res.entry_red, seen_res.entry_red);
          check_field("entry_green", want_res.entry_green, seen_res.entry_green);
          check_field("entry_blue", want_res.entry_blue, seen_res.entry_blue);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int row;
    plan = '{
      '{1'b0, SIG_OK, PLN_OK, 16'd16, 32'd0, 32'd0, 32'd54,
        32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1'b1, bhp_pkg::ERR_NONE},
      '{1'b1, 16'h4D43, PLN_OK, D8, 32'd0, 32'd0, 32'd54,
        32'd0, 32'd0, 0, 0, 1'b1, bhp_pkg::ERR_SIGNATURE},
      '{1'b1, SIG_OK, 16'hFFFF, D8, 32'd0, 32'd0, 32'd54,
        32'd640, 32'd480, 0, 0, 1'b1, bhp_pkg::ERR_PLANES},
      '{1'b1, SIG_OK, PLN_OK, D8, 32'hFFFF_FFFF, 32'd0, 32'd54,
        32'd3, 32'd3, 0, 0, 1'b1, bhp_pkg::ERR_COMPRESSED},
      '{1'b1, SIG_OK, PLN_OK, bhp_pkg::DEPTH_24BPP, 32'd0, 32'd0, 32'd54,
        32'd8, 32'd8, 0, 0, 1'b1, bhp_pkg::ERR_DEPTH},
      '{1'b1, SIG_OK, PLN_OK, D8, 32'd0, 32'hFFFF_FFFF, 32'd54,
        32'd4, 32'd4, 0, 0, 1'b1, bhp_pkg::ERR_PAL_BIG},
      '{1'b1, SIG_OK, PLN_OK, D8, 32'd0, 32'd1, 32'd54,
        32'd5, 32'd5, 0, 1, 1'b1, bhp_pkg::ERR_PAL_CORRUPT},
      '{1'b1, SIG_OK, PLN_OK, D8, 32'd0, 32'd2, 32'd62,
        32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 1'b1, bhp_pkg::ERR_NONE}
    };
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (row = 0; row < PLAN_ROWS; row++) feed_file(plan[row]);
    drain();
    while (sent < ITEM_TOTAL) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else feed_file(draw_file());
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
